>>> rtl/bounding_box_affine_transform_unit_defines.svh
// assertion macros for the bounding box affine transform unit
`ifndef BOUNDING_BOX_AFFINE_TRANSFORM_UNIT_DEFINES_SVH
`define BOUNDING_BOX_AFFINE_TRANSFORM_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off while in reset
`define BBAT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bbat assertion failed");

// delayed implication, the delay in cycles given as argument n
`define BBAT_ASSERT_DELAY(lbl, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("bbat delayed assertion failed");

`endif

>>> rtl/bbat_pkg.sv
// shared constants and register codes for the bounding box affine transform unit
package bbat_pkg;

	// default field widths
	localparam int COORD_BITS_DEF = 24;
	localparam int COEF_BITS_DEF  = 16;

	// configuration register index width and codes
	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ROW_X   = 3'd0,
		REG_ROW_Y   = 3'd1,
		REG_ROW_Z   = 3'd2,
		REG_SHIFT_X = 3'd3,
		REG_SHIFT_Y = 3'd4,
		REG_SHIFT_Z = 3'd5
	} bbat_reg_t;

	// number of output axes
	localparam int AXES = 3;

endpackage

>>> rtl/bbat_cfg_regs.sv
// transform coefficient and translation registers with write decode
module bbat_cfg_regs #(
	parameter int COORD_BITS = 24,
	parameter int COEF_BITS  = 16,
	parameter int DATA_BITS  = 48
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [bbat_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  logic [DATA_BITS-1:0]               wr_data,
	output logic [3*COEF_BITS-1:0]             row [bbat_pkg::AXES],
	output logic signed [COORD_BITS-1:0]       shift [bbat_pkg::AXES]
);
	import bbat_pkg::*;

	localparam int ROW_BITS = 3 * COEF_BITS;
	localparam int FRAC     = COEF_BITS - 4;

	logic [ROW_BITS-1:0]          row_q   [AXES];
	logic signed [COORD_BITS-1:0] shift_q [AXES];

	// register file, reset to the identity transform
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < AXES; r++) begin
				row_q[r]   <= ROW_BITS'(1) << (FRAC + r * COEF_BITS);
				shift_q[r] <= '0;
			end
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ROW_X:   row_q[0]   <= wr_data[ROW_BITS-1:0];
				REG_ROW_Y:   row_q[1]   <= wr_data[ROW_BITS-1:0];
				REG_ROW_Z:   row_q[2]   <= wr_data[ROW_BITS-1:0];
				REG_SHIFT_X: shift_q[0] <= $signed(wr_data[COORD_BITS-1:0]);
				REG_SHIFT_Y: shift_q[1] <= $signed(wr_data[COORD_BITS-1:0]);
				REG_SHIFT_Z: shift_q[2] <= $signed(wr_data[COORD_BITS-1:0]);
				default: ;
			endcase
		end
	end

	assign row   = row_q;
	assign shift = shift_q;

endmodule

>>> rtl/bbat_axis.sv
// one output axis: products, per-term min/max, sums, round and saturate
module bbat_axis #(
	parameter int COORD_BITS = 24,
	parameter int COEF_BITS  = 16
) (
	input  logic                         clk,
	input  logic signed [COORD_BITS-1:0] lo [bbat_pkg::AXES],
	input  logic signed [COORD_BITS-1:0] hi [bbat_pkg::AXES],
	input  logic [3*COEF_BITS-1:0]       row,
	input  logic signed [COORD_BITS-1:0] shift,
	output logic signed [COORD_BITS-1:0] res_lo,
	output logic signed [COORD_BITS-1:0] res_hi
);
	import bbat_pkg::*;

	localparam int FRAC  = COEF_BITS - 4;
	localparam int PBITS = COORD_BITS + COEF_BITS;
	localparam int SBITS = PBITS + 2;
	localparam logic signed [SBITS-1:0] MAXV =
		{{(SBITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [SBITS-1:0] MINV =
		{{(SBITS-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [SBITS-1:0] BIAS =
		{{(SBITS-FRAC){1'b0}}, {FRAC{1'b1}}};

	logic signed [COEF_BITS-1:0] coef [AXES];
	logic signed [PBITS-1:0] prod_lo_s1 [AXES];
	logic signed [PBITS-1:0] prod_hi_s1 [AXES];
	logic signed [PBITS-1:0] mn_s2 [AXES];
	logic signed [PBITS-1:0] mx_s2 [AXES];
	logic signed [SBITS-1:0] acc_mn_s3;
	logic signed [SBITS-1:0] acc_mx_s3;
	logic signed [COORD_BITS-1:0] res_lo_s4;
	logic signed [COORD_BITS-1:0] res_hi_s4;

	// round toward zero to the coordinate grid, then clamp to range
	function automatic logic signed [COORD_BITS-1:0] round_sat(
		input logic signed [SBITS-1:0] acc
	);
		logic signed [SBITS-1:0] t;
		logic signed [SBITS-1:0] q;
		t = acc + (acc[SBITS-1] ? BIAS : '0);
		q = t >>> FRAC;
		if (q > MAXV)
			q = MAXV;
		else if (q < MINV)
			q = MINV;
		return q[COORD_BITS-1:0];
	endfunction

	// coefficient slices, first in the low bits
	always_comb begin
		for (int k = 0; k < AXES; k++)
			coef[k] = $signed(row[k*COEF_BITS +: COEF_BITS]);
	end

	// stage 1: coefficient times both corner values of each term
	always_ff @(posedge clk) begin
		for (int k = 0; k < AXES; k++) begin
			prod_lo_s1[k] <= lo[k] * coef[k];
			prod_hi_s1[k] <= hi[k] * coef[k];
		end
	end

	// stage 2: each term picks its corner independently for the extremes
	always_ff @(posedge clk) begin
		for (int k = 0; k < AXES; k++) begin
			mn_s2[k] <= (prod_lo_s1[k] < prod_hi_s1[k]) ? prod_lo_s1[k] : prod_hi_s1[k];
			mx_s2[k] <= (prod_lo_s1[k] < prod_hi_s1[k]) ? prod_hi_s1[k] : prod_lo_s1[k];
		end
	end

	// stage 3: exact sums with the translation
	always_ff @(posedge clk) begin
		acc_mn_s3 <= SBITS'(mn_s2[0]) + SBITS'(mn_s2[1]) + SBITS'(mn_s2[2])
			+ (SBITS'(shift) <<< FRAC);
		acc_mx_s3 <= SBITS'(mx_s2[0]) + SBITS'(mx_s2[1]) + SBITS'(mx_s2[2])
			+ (SBITS'(shift) <<< FRAC);
	end

	// stage 4: rounding and saturation keep order, so extremes map through
	always_ff @(posedge clk) begin
		res_lo_s4 <= round_sat(acc_mn_s3);
		res_hi_s4 <= round_sat(acc_mx_s3);
	end

	assign res_lo = res_lo_s4;
	assign res_hi = res_hi_s4;

endmodule

>>> rtl/bounding_box_affine_transform_unit.sv
// the start beat passes through the stage valid bits v_s1 to v_s4, and v_s4 is the done strobe
// throughput: one box per cycle, busy never rises, stages advance every cycle
// each axis lane has four stages: multiply, min/max, sum, round
// reset: asynchronous active-low clears stage valid bits and loads the identity transform
// results are shown for one cycle under done; the receiver cannot stall
// top level: bounding box affine transform unit
module bounding_box_affine_transform_unit #(
	parameter int COORD_BITS = bbat_pkg::COORD_BITS_DEF,
	parameter int COEF_BITS  = bbat_pkg::COEF_BITS_DEF,
	parameter int DATA_BITS  = (3 * COEF_BITS > COORD_BITS) ? 3 * COEF_BITS : COORD_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	output logic                              done,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bbat_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DATA_BITS-1:0]              cfg_data,
	input  logic signed [COORD_BITS-1:0]      lo_x,
	input  logic signed [COORD_BITS-1:0]      lo_y,
	input  logic signed [COORD_BITS-1:0]      lo_z,
	input  logic signed [COORD_BITS-1:0]      hi_x,
	input  logic signed [COORD_BITS-1:0]      hi_y,
	input  logic signed [COORD_BITS-1:0]      hi_z,
	input  logic                              box_ok,
	output logic signed [COORD_BITS-1:0]      out_lo_x,
	output logic signed [COORD_BITS-1:0]      out_lo_y,
	output logic signed [COORD_BITS-1:0]      out_lo_z,
	output logic signed [COORD_BITS-1:0]      out_hi_x,
	output logic signed [COORD_BITS-1:0]      out_hi_y,
	output logic signed [COORD_BITS-1:0]      out_hi_z,
	output logic                              out_ok
);
	import bbat_pkg::*;

	`include "bounding_box_affine_transform_unit_defines.svh"

	logic [3*COEF_BITS-1:0]       row   [AXES];
	logic signed [COORD_BITS-1:0] shift [AXES];
	logic signed [COORD_BITS-1:0] lo_vec [AXES];
	logic signed [COORD_BITS-1:0] hi_vec [AXES];
	logic signed [COORD_BITS-1:0] res_lo [AXES];
	logic signed [COORD_BITS-1:0] res_hi [AXES];
	logic v_s1, v_s2, v_s3, v_s4;
	logic ok_s1, ok_s2, ok_s3, ok_s4;
	logic in_beat;

	// handshake: the pipeline never stalls
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign in_beat   = start && !busy;

	// configuration registers
	bbat_cfg_regs #(
		.COORD_BITS (COORD_BITS),
		.COEF_BITS  (COEF_BITS),
		.DATA_BITS  (DATA_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.row      (row),
		.shift    (shift)
	);

	// corner vectors
	assign lo_vec = '{lo_x, lo_y, lo_z};
	assign hi_vec = '{hi_x, hi_y, hi_z};

	// one lane per output axis
	for (genvar g = 0; g < AXES; g++) begin : g_axis
		bbat_axis #(
			.COORD_BITS (COORD_BITS),
			.COEF_BITS  (COEF_BITS)
		) u_axis (
			.clk    (clk),
			.lo     (lo_vec),
			.hi     (hi_vec),
			.row    (row[g]),
			.shift  (shift[g]),
			.res_lo (res_lo[g]),
			.res_hi (res_hi[g])
		);
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_beat;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// box valid flag travels with the data
	always_ff @(posedge clk) begin
		ok_s1 <= box_ok;
		ok_s2 <= ok_s1;
		ok_s3 <= ok_s2;
		ok_s4 <= ok_s3;
	end

	// result beat, zeroed for an invalid box
	assign done     = v_s4;
	assign out_ok   = ok_s4;
	assign out_lo_x = ok_s4 ? res_lo[0] : '0;
	assign out_lo_y = ok_s4 ? res_lo[1] : '0;
	assign out_lo_z = ok_s4 ? res_lo[2] : '0;
	assign out_hi_x = ok_s4 ? res_hi[0] : '0;
	assign out_hi_y = ok_s4 ? res_hi[1] : '0;
	assign out_hi_z = ok_s4 ? res_hi[2] : '0;

	// checks
	`BBAT_ASSERT_DELAY(a_latency, in_beat, 4, done)
	`BBAT_ASSERT_IMP(a_ordered, done && out_ok,
		out_lo_x <= out_hi_x && out_lo_y <= out_hi_y && out_lo_z <= out_hi_z)
	`BBAT_ASSERT_DELAY(a_invalid_zero, in_beat && !box_ok, 4,
		!out_ok && out_lo_x == '0 && out_hi_z == '0)

endmodule

>>> tb/bbat_box_checker.sv
// box checker: mirrors the transform registers, predicts each result box and compares it
`timescale 1ns / 100ps
module bbat_box_checker #(
	parameter int COORD_BITS = bbat_pkg::COORD_BITS_DEF,
	parameter int COEF_BITS  = bbat_pkg::COEF_BITS_DEF,
	parameter int DATA_BITS  = (3 * COEF_BITS > COORD_BITS) ? 3 * COEF_BITS : COORD_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic                              done,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [bbat_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DATA_BITS-1:0]              cfg_data,
	input  logic signed [COORD_BITS-1:0]      lo_x,
	input  logic signed [COORD_BITS-1:0]      lo_y,
	input  logic signed [COORD_BITS-1:0]      lo_z,
	input  logic signed [COORD_BITS-1:0]      hi_x,
	input  logic signed [COORD_BITS-1:0]      hi_y,
	input  logic signed [COORD_BITS-1:0]      hi_z,
	input  logic                              box_ok,
	input  logic signed [COORD_BITS-1:0]      out_lo_x,
	input  logic signed [COORD_BITS-1:0]      out_lo_y,
	input  logic signed [COORD_BITS-1:0]      out_lo_z,
	input  logic signed [COORD_BITS-1:0]      out_hi_x,
	input  logic signed [COORD_BITS-1:0]      out_hi_y,
	input  logic signed [COORD_BITS-1:0]      out_hi_z,
	input  logic                              out_ok,
	output int                                pending,
	output int                                fail_count
);
	import bbat_pkg::*;

	localparam int COEF_FRAC = COEF_BITS - 4;
	localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	localparam logic [3*COEF_BITS-1:0] UNIT_COEF = 1;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] lo_x;
		logic signed [COORD_BITS-1:0] lo_y;
		logic signed [COORD_BITS-1:0] lo_z;
		logic signed [COORD_BITS-1:0] hi_x;
		logic signed [COORD_BITS-1:0] hi_y;
		logic signed [COORD_BITS-1:0] hi_z;
		logic                         ok;
	} box_t;

	// shadow copy of the transform registers
	logic [3*COEF_BITS-1:0]       coef_rows [AXES];
	logic signed [COORD_BITS-1:0] offsets   [AXES];

	box_t expected_boxes [$];
	box_t in_box;
	box_t oldest_box;
	int   mismatches = 0;

	assign in_box = {lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, box_ok};
	assign fail_count = mismatches;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// one output axis of one corner, truncated toward zero and saturated
	function automatic longint axis_value(int axis, longint px, longint py, longint pz);
		logic signed [COEF_BITS-1:0] c0;
		logic signed [COEF_BITS-1:0] c1;
		logic signed [COEF_BITS-1:0] c2;
		longint acc;
		longint q;
		c0 = coef_rows[axis][0 +: COEF_BITS];
		c1 = coef_rows[axis][COEF_BITS +: COEF_BITS];
		c2 = coef_rows[axis][2*COEF_BITS +: COEF_BITS];
		acc = longint'(c0) * px + longint'(c1) * py + longint'(c2) * pz
			+ longint'(offsets[axis]) * (longint'(1) <<< COEF_FRAC);
		if (acc < 0)
			q = -((-acc) >>> COEF_FRAC);
		else
			q = acc >>> COEF_FRAC;
		if (q > COORD_MAX)
			q = COORD_MAX;
		if (q < COORD_MIN)
			q = COORD_MIN;
		return q;
	endfunction

	// enclosing box of the eight transformed corners, all zero for an invalid box
	function automatic box_t predict_box(box_t b);
		box_t   r;
		longint px;
		longint py;
		longint pz;
		longint v;
		longint mn [AXES];
		longint mx [AXES];
		r = '0;
		if (!b.ok)
			return r;
		for (int c = 0; c < 8; c++) begin
			px = c[2] ? b.hi_x : b.lo_x;
			py = c[1] ? b.hi_y : b.lo_y;
			pz = c[0] ? b.hi_z : b.lo_z;
			for (int a = 0; a < AXES; a++) begin
				v = axis_value(a, px, py, pz);
				if (c == 0 || v < mn[a])
					mn[a] = v;
				if (c == 0 || v > mx[a])
					mx[a] = v;
			end
		end
		r.lo_x = COORD_BITS'(mn[0]);
		r.lo_y = COORD_BITS'(mn[1]);
		r.lo_z = COORD_BITS'(mn[2]);
		r.hi_x = COORD_BITS'(mx[0]);
		r.hi_y = COORD_BITS'(mx[1]);
		r.hi_z = COORD_BITS'(mx[2]);
		r.ok = 1'b1;
		return r;
	endfunction

	// register writes, predictions on start beats, comparison on done strobes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_rows[0] <= UNIT_COEF << COEF_FRAC;
			coef_rows[1] <= UNIT_COEF << (COEF_FRAC + COEF_BITS);
			coef_rows[2] <= UNIT_COEF << (COEF_FRAC + 2 * COEF_BITS);
			offsets[0] <= '0;
			offsets[1] <= '0;
			offsets[2] <= '0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROW_X:   coef_rows[0] <= cfg_data[3*COEF_BITS-1:0];
					REG_ROW_Y:   coef_rows[1] <= cfg_data[3*COEF_BITS-1:0];
					REG_ROW_Z:   coef_rows[2] <= cfg_data[3*COEF_BITS-1:0];
					REG_SHIFT_X: offsets[0] <= cfg_data[COORD_BITS-1:0];
					REG_SHIFT_Y: offsets[1] <= cfg_data[COORD_BITS-1:0];
					REG_SHIFT_Z: offsets[2] <= cfg_data[COORD_BITS-1:0];
					default: ;
				endcase
			end
			if (done) begin
				if (expected_boxes.size() == 0) begin
					report_mismatch("done strobe with no box pending", 1, 0);
				end else begin
					oldest_box = expected_boxes.pop_front();
					if (out_lo_x !== oldest_box.lo_x)
						report_mismatch("out_lo_x", out_lo_x, oldest_box.lo_x);
					if (out_lo_y !== oldest_box.lo_y)
						report_mismatch("out_lo_y", out_lo_y, oldest_box.lo_y);
					if (out_lo_z !== oldest_box.lo_z)
						report_mismatch("out_lo_z", out_lo_z, oldest_box.lo_z);
					if (out_hi_x !== oldest_box.hi_x)
						report_mismatch("out_hi_x", out_hi_x, oldest_box.hi_x);
					if (out_hi_y !== oldest_box.hi_y)
						report_mismatch("out_hi_y", out_hi_y, oldest_box.hi_y);
					if (out_hi_z !== oldest_box.hi_z)
						report_mismatch("out_hi_z", out_hi_z, oldest_box.hi_z);
					if (out_ok !== oldest_box.ok)
						report_mismatch("out_ok", out_ok, oldest_box.ok);
				end
			end
			if (start && !busy)
				expected_boxes.push_back(predict_box(in_box));
			pending <= expected_boxes.size();
		end
	end

endmodule

>>> tb/tb_bounding_box_affine_transform_unit.sv
// testbench top for the bounding box affine transform unit: stimulus, watchdog and verdict
`timescale 1ns / 100ps
module tb_bounding_box_affine_transform_unit;
	import bbat_pkg::*;

	localparam int COORD_BITS = COORD_BITS_DEF;
	localparam int COEF_BITS  = COEF_BITS_DEF;
	localparam int DATA_BITS  = (3 * COEF_BITS > COORD_BITS) ? 3 * COEF_BITS : COORD_BITS;
	localparam int LATENCY       = 4;
	localparam int IDLE_LIMIT    = 2000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_BOXES   = 228;
	localparam int NEAR_COEF     = 1 << (COEF_BITS - 3);

	localparam logic signed [COORD_BITS-1:0] CRD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] CRD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic [COEF_BITS-1:0] COEF_MAX  = {1'b0, {(COEF_BITS-1){1'b1}}};
	localparam logic [COEF_BITS-1:0] COEF_MIN  = {1'b1, {(COEF_BITS-1){1'b0}}};
	localparam logic [COEF_BITS-1:0] COEF_ONE  = 1 << (COEF_BITS - 4);
	localparam logic [COEF_BITS-1:0] COEF_ZERO = '0;

	// indexes past the register file, writes there are dropped
	localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_B = 3'd7;

	typedef enum int {SPAN_FULL, SPAN_EDGE, SPAN_NEAR} span_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         done;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [CFG_IDX_BITS-1:0]      cfg_index;
	logic [DATA_BITS-1:0]         cfg_data;
	logic signed [COORD_BITS-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
	logic                         box_ok;
	logic signed [COORD_BITS-1:0] out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z;
	logic                         out_ok;
	int                           pending;
	int                           fail_count;
	int                           idle_cycles = 0;

	// transform to load on the next register pass
	logic [3*COEF_BITS-1:0]       next_rows   [AXES];
	logic signed [COORD_BITS-1:0] next_shifts [AXES];

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	bounding_box_affine_transform_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.lo_x(lo_x), .lo_y(lo_y), .lo_z(lo_z), .hi_x(hi_x), .hi_y(hi_y), .hi_z(hi_z),
		.box_ok(box_ok),
		.out_lo_x(out_lo_x), .out_lo_y(out_lo_y), .out_lo_z(out_lo_z),
		.out_hi_x(out_hi_x), .out_hi_y(out_hi_y), .out_hi_z(out_hi_z), .out_ok(out_ok)
	);

	bbat_box_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.lo_x(lo_x), .lo_y(lo_y), .lo_z(lo_z), .hi_x(hi_x), .hi_y(hi_y), .hi_z(hi_z),
		.box_ok(box_ok),
		.out_lo_x(out_lo_x), .out_lo_y(out_lo_y), .out_lo_z(out_lo_z),
		.out_hi_x(out_hi_x), .out_hi_y(out_hi_y), .out_hi_z(out_hi_z), .out_ok(out_ok),
		.pending(pending), .fail_count(fail_count)
	);

	// watchdog on cycles with no beat of any kind
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** bounding_box_affine_transform_unit: FAILED **");
			$finish;
		end
	end

	function automatic logic signed [COORD_BITS-1:0] rand_coord(span_t s);
		logic [31:0]        r;
		logic signed [15:0] m;
		r = $urandom;
		m = r[15:0];
		case (s)
			SPAN_FULL: return r[COORD_BITS-1:0];
			SPAN_EDGE: begin
				case ($urandom_range(0, 3))
					0: return CRD_MAX;
					1: return CRD_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return COORD_BITS'(m);
		endcase
	endfunction

	function automatic logic [COEF_BITS-1:0] rand_coef(span_t s);
		logic signed [COEF_BITS-1:0] c;
		case (s)
			SPAN_FULL: c = COEF_BITS'($urandom);
			SPAN_EDGE: begin
				case ($urandom_range(0, 3))
					0: c = COEF_MAX;
					1: c = COEF_MIN;
					2: c = COEF_ZERO;
					default: c = COEF_ONE;
				endcase
			end
			default: c = COEF_BITS'(int'($urandom_range(0, 2 * NEAR_COEF)) - NEAR_COEF);
		endcase
		return c;
	endfunction

	// one start beat, held until the block takes it
	task automatic send_box(input logic signed [COORD_BITS-1:0] lx, ly, lz, hx, hy, hz,
			input logic ok);
		start <= 1'b1;
		lo_x <= lx;
		lo_y <= ly;
		lo_z <= lz;
		hi_x <= hx;
		hi_y <= hy;
		hi_z <= hz;
		box_ok <= ok;
		do @(posedge clk); while (busy);
	endtask

	// sender gap, junk on the payload while start is low
	task automatic pause(input int cycles);
		start <= 1'b0;
		lo_x <= COORD_BITS'($urandom);
		lo_y <= COORD_BITS'($urandom);
		lo_z <= COORD_BITS'($urandom);
		hi_x <= COORD_BITS'($urandom);
		hi_y <= COORD_BITS'($urandom);
		hi_z <= COORD_BITS'($urandom);
		box_ok <= 1'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// drain all results, then give the pipeline time to empty
	task automatic settle();
		pause(1);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic cfg_beat(input logic [CFG_IDX_BITS-1:0] idx, input logic [DATA_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// write every register from next_rows and next_shifts, plus one dropped write
	task automatic load_transform();
		logic [DATA_BITS-1:0] word [AXES];
		for (int a = 0; a < AXES; a++) begin
			word[a] = DATA_BITS'({$urandom, $urandom});
			word[a][COORD_BITS-1:0] = next_shifts[a];
		end
		cfg_beat(REG_ROW_X, next_rows[0]);
		cfg_beat(REG_ROW_Y, next_rows[1]);
		cfg_beat(REG_ROW_Z, next_rows[2]);
		cfg_beat(REG_SHIFT_X, word[0]);
		cfg_beat(REG_SHIFT_Y, word[1]);
		cfg_beat(REG_SHIFT_Z, word[2]);
		cfg_beat($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B,
			DATA_BITS'({$urandom, $urandom}));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// corner cases: zero box, extreme corners, inverted box, invalid box
	task automatic directed_boxes();
		send_box('0, '0, '0, '0, '0, '0, 1'b1);
		send_box(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, 1'b1);
		send_box(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, 1'b1);
		send_box(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX, 1'b1);
		send_box(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MIN, CRD_MIN, CRD_MIN, 1'b1);
		send_box('1, CRD_MAX, CRD_MIN, '1, CRD_MIN, CRD_MAX, 1'b0);
	endtask

	// random boxes in bursts with random gaps
	task automatic random_boxes(input int count);
		int                           burst;
		int                           pick;
		span_t                        s;
		bit                           ordered;
		logic signed [COORD_BITS-1:0] lo [AXES];
		logic signed [COORD_BITS-1:0] hi [AXES];
		logic signed [COORD_BITS-1:0] t;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			if (burst == 0) begin
				burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
				if ($urandom_range(0, 3) != 0)
					pause($urandom_range(1, 10));
			end
			burst--;
			pick = $urandom_range(0, 9);
			s = (pick < 2) ? SPAN_FULL : (pick < 3) ? SPAN_EDGE : SPAN_NEAR;
			ordered = ($urandom_range(0, 6) != 0);
			for (int a = 0; a < AXES; a++) begin
				lo[a] = rand_coord(s);
				hi[a] = rand_coord(s);
				if (ordered && lo[a] > hi[a]) begin
					t = lo[a];
					lo[a] = hi[a];
					hi[a] = t;
				end
			end
			send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom_range(0, 9) != 0);
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ROW_X;
		cfg_data <= '0;
		lo_x <= '0;
		lo_y <= '0;
		lo_z <= '0;
		hi_x <= '0;
		hi_y <= '0;
		hi_z <= '0;
		box_ok <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity transform from reset
		directed_boxes();
		settle();

		// largest positive coefficients and shifts
		for (int a = 0; a < AXES; a++) begin
			next_rows[a] = {COEF_MAX, COEF_MAX, COEF_MAX};
			next_shifts[a] = CRD_MAX;
		end
		load_transform();
		directed_boxes();
		settle();

		// most negative coefficients and shifts
		for (int a = 0; a < AXES; a++) begin
			next_rows[a] = {COEF_MIN, COEF_MIN, COEF_MIN};
			next_shifts[a] = CRD_MIN;
		end
		load_transform();
		directed_boxes();
		settle();

		// mixed signs, overflow in both directions within one box
		next_rows[0] = {COEF_ZERO, COEF_MIN, COEF_MAX};
		next_rows[1] = {COEF_MAX, COEF_ZERO, COEF_MIN};
		next_rows[2] = {COEF_MIN, COEF_MAX, COEF_ONE};
		next_shifts[0] = '0;
		next_shifts[1] = '1;
		next_shifts[2] = CRD_MAX;
		load_transform();
		directed_boxes();
		settle();

		// random transforms, each followed by a random box stream
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			for (int a = 0; a < AXES; a++) begin
				next_rows[a] = {rand_coef(span_t'($urandom_range(0, 2))),
					rand_coef(span_t'($urandom_range(0, 2))),
					rand_coef(span_t'($urandom_range(0, 2)))};
				next_shifts[a] = rand_coord(span_t'($urandom_range(0, 2)));
			end
			load_transform();
			random_boxes(PHASE_BOXES);
			settle();
		end

		repeat (LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("** bounding_box_affine_transform_unit: PASSED **");
		else
			$display("** bounding_box_affine_transform_unit: FAILED **");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/bbat_pkg.sv
rtl/bbat_cfg_regs.sv
rtl/bbat_axis.sv
rtl/bounding_box_affine_transform_unit.sv
tb/bbat_box_checker.sv
tb/tb_bounding_box_affine_transform_unit.sv
